FILE: hw/rtl/sra_pkg.sv
// Shared types and constants for the SPI register access master.
// Used by the front end, the slot queue, the shift engine and the top level.
package sra_pkg;

  localparam logic [7:0] WRITE_FLAG        = 8'h80;
  localparam logic [6:0] ADDR_MASK         = 7'h7F;
  localparam logic [7:0] HALF_PERIOD_RESET = 8'd8;
  localparam int         QUEUE_DEPTH       = 4;

  // One SPI byte slot, as classified by the front end.
  typedef struct packed {
    logic [7:0] mosi;
    logic [7:0] miso;
    logic       is_read;
    logic       is_address;
    logic       deselect;
    logic       result_last;
  } slot_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOW,
    BK_HIGH,
    BK_DESEL,
    BK_DONE
  } back_state_t;

endpackage

FILE: hw/rtl/spi_register_access_master.sv
// Top level of the SPI register access master: config register, front end,
// slot queue and shift engine. Depends on sra_pkg, sra_front, sra_queue, sra_back.
//
// Input channel (in_valid / in_stall): one transaction is one data byte of a
//   register burst. The first byte of a frame (first set, or no frame open)
//   also produces an address slot ahead of its data slot; last releases chip
//   select after the byte.
// Output channel (out_valid / out_stall): one transaction per SPI byte slot;
//   result_last marks the final slot of an input transaction.
// Config channel (cfg_valid / cfg_ready): writes half_period, the SCK half
//   period in clocks (zero runs as one). cfg_ready is always high; write it
//   only while the block is idle.
// Each byte slot is taken from the queue, shifted out as eight bits on SCK,
// and loaded into the output register; when chip select is released, a
// release delay comes before that load. An item that opens a frame costs
// two slots.
// Input is taken while earlier slots are still shifting, up to the queue depth.
// Stall on the output holds the finished slot and, behind it, the engine and
// then the input. Reset closes any frame, empties the queue, sets half_period
// to 8 and drops out_valid.
module spi_register_access_master import sra_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [6:0] reg_addr,
  input  logic [7:0] wr_data,
  input  logic [7:0] slave_byte,
  input  logic       first,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] mosi_byte,
  output logic [7:0] read_data,
  output logic       is_address,
  output logic       deselect,
  output logic       result_last
);

  logic [7:0] half_period;
  logic       q_full;
  logic       q_valid;
  logic       push;
  logic       pop;
  slot_t      push_slot;
  slot_t      head;

  // Config register: always ready, one write per transaction.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  // Classify items and track the frame.
  sra_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .reg_addr   (reg_addr),
    .wr_data    (wr_data),
    .slave_byte (slave_byte),
    .first      (first),
    .last       (last),
    .q_full     (q_full),
    .push       (push),
    .push_slot  (push_slot)
  );

  // Decouple classification from the slow shift engine.
  sra_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_slot (push_slot),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  // Shift each slot out on the SPI lines and report it.
  sra_back u_back (
    .clk         (clk),
    .rst         (rst),
    .half_period (half_period),
    .q_valid     (q_valid),
    .slot        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mosi_byte   (mosi_byte),
    .read_data   (read_data),
    .is_address  (is_address),
    .deselect    (deselect),
    .result_last (result_last)
  );

endmodule

FILE: hw/rtl/sra_front.sv
// Front end: accepts input items, tracks the open frame, splits an item into
// an address slot and a data slot. Depends on sra_pkg.
module sra_front import sra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [6:0] reg_addr,
  input  logic [7:0] wr_data,
  input  logic [7:0] slave_byte,
  input  logic       first,
  input  logic       last,
  input  logic       q_full,
  output logic       push,
  output slot_t      push_slot
);

  logic  frame_open;
  logic  frame_is_read;
  logic  pend_valid;
  slot_t pend;

  logic  accept;
  logic  need_addr;
  logic  data_is_read;
  slot_t addr_slot;
  slot_t data_slot;

  assign in_stall = pend_valid || q_full;
  assign accept   = in_valid && !in_stall;
  assign need_addr = first || !frame_open;
  assign data_is_read = need_addr ? opcode : frame_is_read;

  always_comb begin
    addr_slot.mosi        = opcode ? {1'b0, reg_addr & ADDR_MASK}
                                   : ({1'b0, reg_addr} | WRITE_FLAG);
    addr_slot.miso        = 8'd0;
    addr_slot.is_read     = 1'b0;
    addr_slot.is_address  = 1'b1;
    addr_slot.deselect    = 1'b0;
    addr_slot.result_last = 1'b0;

    data_slot.mosi        = data_is_read ? 8'd0 : wr_data;
    data_slot.miso        = slave_byte;
    data_slot.is_read     = data_is_read;
    data_slot.is_address  = 1'b0;
    data_slot.deselect    = last;
    data_slot.result_last = 1'b1;
  end

  // Pending data slot goes first; otherwise push straight from the input.
  always_comb begin
    push      = 1'b0;
    push_slot = data_slot;
    if (pend_valid) begin
      push      = !q_full;
      push_slot = pend;
    end else if (accept) begin
      push      = 1'b1;
      push_slot = need_addr ? addr_slot : data_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open    <= 1'b0;
      frame_is_read <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        frame_open <= !last;
        if (need_addr) begin
          frame_is_read <= opcode;
          pend_valid    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && need_addr) begin
      pend <= data_slot;
    end
  end

`ifndef SYNTH
  a_pend_drains: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !q_full) |=> !pend_valid)
    else $error("pending data slot not drained");
`endif

endmodule

FILE: hw/rtl/sra_queue.sv
// Short slot queue between the front end and the shift engine.
// Register based, one push and one pop per cycle. Depends on sra_pkg.
module sra_queue import sra_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  slot_t push_slot,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output slot_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  slot_t            entry [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_slot;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("slot queue overflow");
`endif

endmodule

FILE: hw/rtl/sra_back.sv
// Shift engine: runs one SPI byte slot at a time in mode 0, MSB first,
// with the chip-select release delay, into an output register. Depends on sra_pkg.
module sra_back import sra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] half_period,
  input  logic       q_valid,
  input  slot_t      slot,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] mosi_byte,
  output logic [7:0] read_data,
  output logic       is_address,
  output logic       deselect,
  output logic       result_last
);

  back_state_t state;
  back_state_t state_next;

  slot_t       cur;
  logic [7:0]  timer;
  logic [2:0]  bit_cnt;
  logic [7:0]  tx_sr;
  logic [7:0]  tx_cap;
  logic [7:0]  miso_sr;
  logic [7:0]  rx_sr;

  logic        load_slot;
  logic        load_timer;
  logic        dec_timer;
  logic        start_high;
  logic        next_bit;
  logic        load_out;
  logic [7:0]  timer_load;

  // A zero half period runs as one clock.
  assign timer_load = (half_period == 8'd0) ? 8'd0 : half_period - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_slot  = 1'b0;
    load_timer = 1'b0;
    dec_timer  = 1'b0;
    start_high = 1'b0;
    next_bit   = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          load_slot  = 1'b1;
          load_timer = 1'b1;
          state_next = BK_LOW;
        end
      end
      BK_LOW: begin
        if (timer == 8'd0) begin
          start_high = 1'b1;
          load_timer = 1'b1;
          state_next = BK_HIGH;
        end else begin
          dec_timer = 1'b1;
        end
      end
      BK_HIGH: begin
        if (timer == 8'd0) begin
          load_timer = 1'b1;
          if (bit_cnt == 3'd0) begin
            state_next = cur.deselect ? BK_DESEL : BK_DONE;
          end else begin
            next_bit   = 1'b1;
            state_next = BK_LOW;
          end
        end else begin
          dec_timer = 1'b1;
        end
      end
      BK_DESEL: begin
        if (timer == 8'd0) begin
          state_next = BK_DONE;
        end else begin
          dec_timer = 1'b1;
        end
      end
      BK_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_timer) begin
      timer <= timer_load;
    end else if (dec_timer) begin
      timer <= timer - 8'd1;
    end
    if (load_slot) begin
      cur     <= slot;
      bit_cnt <= 3'd7;
      tx_sr   <= slot.mosi;
      miso_sr <= slot.miso;
    end
    if (next_bit) begin
      bit_cnt <= bit_cnt - 3'd1;
      tx_sr   <= {tx_sr[6:0], 1'b0};
    end
    // Rising SCK edge: sample both lines.
    if (start_high) begin
      tx_cap  <= {tx_cap[6:0], tx_sr[7]};
      rx_sr   <= {rx_sr[6:0], miso_sr[7]};
      miso_sr <= {miso_sr[6:0], 1'b0};
    end
    if (load_out) begin
      mosi_byte   <= tx_cap;
      read_data   <= cur.is_read ? rx_sr : 8'd0;
      is_address  <= cur.is_address;
      deselect    <= cur.deselect;
      result_last <= cur.result_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == BK_IDLE && q_valid)
    else $error("slot taken outside idle");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE && (!out_valid || !out_stall)) |=> out_valid && state == BK_IDLE)
    else $error("finished slot not delivered");
  a_addr_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_address) |-> read_data == 8'd0 && !deselect && !result_last)
    else $error("address slot carries data fields");
`endif

endmodule
